>>> rtl/core/ecei_pkg.sv
// Shared constants, codes and control types of the easing curve evaluator.
package ecei_pkg;

   // Fixed point format: Q1.16 with 65536 standing for 1.0.
   localparam int FRAC_BITS = 16;
   localparam int OPND_W    = 18;
   localparam int RES_W     = FRAC_BITS + 1;
   localparam int STEPS_W   = 5;

   localparam logic [STEPS_W-1:0] STEPS_RESET = STEPS_W'(16);

   localparam logic [RES_W-1:0] ONE  = RES_W'(1 << FRAC_BITS);
   localparam logic [RES_W-1:0] HALF = RES_W'(1 << (FRAC_BITS - 1));

   // Shared multiplier: first pass is a 17x18 product, second pass multiplies
   // that product by an 18-bit factor.
   localparam int MUL_A_W = 2 * RES_W;
   localparam int MUL_B_W = RES_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam logic [MUL_B_W-1:0] ONE_B   = MUL_B_W'(1 << FRAC_BITS);
   localparam logic [MUL_B_W-1:0] TWO_B   = MUL_B_W'(2 << FRAC_BITS);
   localparam logic [MUL_B_W-1:0] THREE_B = MUL_B_W'(3 << FRAC_BITS);

   // Opcodes.
   localparam logic OP_EVAL    = 1'b0;
   localparam logic OP_INVERSE = 1'b1;

   // Easing types; every other code is smoothstep.
   localparam logic [2:0] EASE_LINEAR = 3'd0;
   localparam logic [2:0] EASE_IN     = 3'd1;
   localparam logic [2:0] EASE_OUT    = 3'd2;
   localparam logic [2:0] EASE_CUBIC  = 3'd3;

   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic update;
      logic out_load;
   } ecei_cmd_type;

   typedef struct packed {
      logic op_inverse;
      logic shortcut;
   } ecei_stat_type;

endpackage

>>> rtl/core/ecei_if.sv
// Request and response channel interfaces of the easing curve evaluator.
interface ecei_req_if;
   import ecei_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     opcode;
   logic [2:0]               easing_type;
   logic signed [OPND_W-1:0] operand_value;

   modport source (output valid, output opcode, output easing_type,
                   output operand_value, input ready);
   modport sink   (input valid, input opcode, input easing_type,
                   input operand_value, output ready);
endinterface

interface ecei_rsp_if;
   import ecei_pkg::*;

   logic             valid;
   logic             ready;
   logic [RES_W-1:0] result_value;

   modport source (output valid, output result_value, input ready);
   modport sink   (input valid, input result_value, output ready);
endinterface

>>> rtl/core/ecei_datapath.sv
// Datapath: operand clamp, shared multiplier, curve value and bisection interval.
module ecei_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  ecei_pkg::ecei_cmd_type        cmd,
   output ecei_pkg::ecei_stat_type       stat,
   input  logic                          req_opcode,
   input  logic [2:0]                    req_easing_type,
   input  logic signed [ecei_pkg::OPND_W-1:0] req_operand_value,
   output logic [ecei_pkg::RES_W-1:0]    rsp_result_value
);
   import ecei_pkg::*;

   logic                 op_ff, op_in;
   logic [2:0]           type_ff, type_in;
   logic [RES_W-1:0]     target_ff, target_in;
   logic [RES_W-1:0]     lo_ff, lo_in;
   logic [RES_W-1:0]     hi_ff, hi_in;
   logic [MUL_A_W-1:0]   p1_ff, p1_in;
   logic [PROD_W-1:0]    p2_ff, p2_in;
   logic [RES_W-1:0]     res_ff, res_in;

   logic [RES_W-1:0]     clamped;
   logic [RES_W:0]       mid_sum;
   logic [RES_W-1:0]     mid;
   logic [RES_W-1:0]     x_cur;
   logic [RES_W-1:0]     v_cur;
   logic                 upper;
   logic [RES_W-1:0]     a1;
   logic [MUL_B_W-1:0]   b1;
   logic [MUL_B_W-1:0]   c2;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [PROD_W-1:0]    product;
   logic [RES_W-1:0]     q;
   logic                 inexact;
   logic [RES_W-1:0]     curve_val;

   // Negative operands count as zero, operands above one as one.
   always_comb begin
      if (req_operand_value[OPND_W-1]) begin
         clamped = '0;
      end else if (req_operand_value[RES_W-1:0] > ONE) begin
         clamped = ONE;
      end else begin
         clamped = req_operand_value[RES_W-1:0];
      end
   end

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[RES_W:1];
   assign x_cur   = (op_ff == OP_INVERSE) ? mid : target_ff;
   assign v_cur   = ONE - x_cur;
   assign upper   = (x_cur >= HALF);

   // Every curve is written as floor(a*b*c / ONE^2), but the upper cubic half as floor(ONE - a*b*c / ONE^2).
   always_comb begin
      a1 = x_cur;
      b1 = {1'b0, x_cur};
      c2 = ONE_B;
      case (type_ff)
         EASE_LINEAR: begin
            b1 = ONE_B;
         end
         EASE_IN: begin
            c2 = ONE_B;
         end
         EASE_OUT: begin
            b1 = TWO_B - {1'b0, x_cur};
         end
         EASE_CUBIC: begin
            if (upper) begin
               a1 = v_cur;
               b1 = {1'b0, v_cur};
               c2 = {v_cur[RES_W-2:0], 2'b00};
            end else begin
               c2 = {x_cur[RES_W-2:0], 2'b00};
            end
         end
         default: begin
            c2 = THREE_B - {x_cur, 1'b0};
         end
      endcase
   end

   assign mul_a   = cmd.mul2 ? p1_ff : MUL_A_W'(a1);
   assign mul_b   = cmd.mul2 ? c2 : b1;
   assign product = mul_a * mul_b;

   assign q       = p2_ff[2*FRAC_BITS +: RES_W];
   assign inexact = |p2_ff[2*FRAC_BITS-1:0];

   // The upper half of the cubic is one minus a cubic, floored.
   assign curve_val = ((type_ff == EASE_CUBIC) && upper) ?
                      (ONE - q - RES_W'(inexact)) : q;

   assign stat.op_inverse = (op_ff == OP_INVERSE);
   assign stat.shortcut   = (target_ff == '0) || (target_ff == ONE) ||
                            (type_ff == EASE_LINEAR);

   always_comb begin
      op_in     = op_ff;
      type_in   = type_ff;
      target_in = target_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;
      res_in    = res_ff;
      if (cmd.load) begin
         op_in     = req_opcode;
         type_in   = req_easing_type;
         target_in = clamped;
         lo_in     = '0;
         hi_in     = ONE;
      end
      if (cmd.mul1) begin
         p1_in = product[MUL_A_W-1:0];
      end
      if (cmd.mul2) begin
         p2_in = product;
      end
      if (cmd.update) begin
         if (curve_val < target_ff) begin
            lo_in = mid;
         end else begin
            hi_in = mid;
         end
      end
      if (cmd.out_load) begin
         if (op_ff == OP_EVAL) begin
            res_in = curve_val;
         end else if (stat.shortcut) begin
            res_in = target_ff;
         end else begin
            res_in = mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      type_ff   <= type_in;
      target_ff <= target_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      p1_ff     <= p1_in;
      p2_ff     <= p2_in;
      res_ff    <= res_in;
   end

   assign rsp_result_value = res_ff;

   // A halving never turns the search interval around.
   a_interval_ordered: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> (lo_ff <= hi_ff))
      else $error("bisection interval inverted");

endmodule

>>> rtl/core/ecei_ctrl.sv
// Controller: sequencing state machine, step counter and step count register.
module ecei_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           csr_wr_en,
   input  logic [ecei_pkg::STEPS_W-1:0]   csr_wr_data,
   input  ecei_pkg::ecei_stat_type        stat,
   output ecei_pkg::ecei_cmd_type         cmd
);
   import ecei_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECIDE = 6'b000010,
      ST_MUL1   = 6'b000100,
      ST_MUL2   = 6'b001000,
      ST_EVAL   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [STEPS_W-1:0]   cnt_ff, cnt_in;
   logic [STEPS_W-1:0]   steps_ff, steps_in;
   logic                 out_valid_ff, out_valid_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cnt_in = '0;
            if (!stat.op_inverse) begin
               state_in = ST_MUL1;
            end else if (stat.shortcut || (steps_ff == '0)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!stat.op_inverse) begin
               state_in = ST_DONE;
            end else begin
               cmd.update = 1'b1;
               cnt_in     = cnt_ff + 1'b1;
               if (((STEPS_W+1)'(cnt_ff) + 1'b1) == (STEPS_W+1)'(steps_ff)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_MUL1;
               end
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign steps_in  = csr_wr_en ? csr_wr_data : steps_ff;
   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         steps_ff     <= STEPS_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         steps_ff     <= steps_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // A forward evaluation always takes the two multiplier passes and finishes.
   a_eval_latency: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && !stat.op_inverse) |-> ##4 (state_ff == ST_DONE))
      else $error("forward evaluation did not reach completion in time");

   // A finished result moves out once the output side frees up.
   a_done_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_ready) |=> (state_ff == ST_IDLE && rsp_valid))
      else $error("finished result was not handed to the output register");

   // A transaction only starts work from idle.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DECIDE && !rsp_valid ||
                                    state_ff == ST_DECIDE))
      else $error("accepted transaction did not start the sequence");

endmodule

>>> rtl/core/easing_curve_eval_inverse.sv
// Top level of the easing curve evaluator with bisection inverse.
//
// The block takes one transaction at a time on the request channel: an
// opcode, an easing type and a signed Q1.16 operand, which is clamped to the
// range 0 to 1.0 (65536). Opcode 0 returns the eased value of the curve at that
// time; opcode 1 returns the time at which the curve reaches the operand as a
// target, found by bisection with the number of halvings held in the CSR
// (reset value 16, written through csr_wr_en and csr_wr_data; the user must
// write it only while the block is idle, which the block does not enforce).
// Every curve value is computed exactly and floored to 16 fractional bits. One
// 34x18 multiplier is shared and used twice per curve evaluation (states MUL1,
// MUL2, EVAL). A forward evaluation runs DECIDE, one curve evaluation and DONE;
// an inverse repeats the curve evaluation once per halving and goes from DECIDE
// straight to DONE when the target is 0, 1.0 or the curve is linear. The
// request channel is ready again once the result has moved into the output
// register, and a new item is taken only after the last one is finished. The
// output register holds a finished result until the response transaction
// completes, while the block already works on the next item.
module easing_curve_eval_inverse (
   input  logic                          clock,
   input  logic                          reset,
   ecei_req_if.sink                      req_bus,
   ecei_rsp_if.source                    rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [ecei_pkg::STEPS_W-1:0]  csr_wr_data
);
   import ecei_pkg::*;

   // Command and status bundles between the controller and the datapath.
   ecei_cmd_type  cmd;
   ecei_stat_type stat;

   // The controller owns the handshakes, the halving counter and the CSR.
   ecei_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stat        (stat),
      .cmd         (cmd)
   );

   // The datapath captures the request, runs the multiplier passes, keeps the
   // search interval and holds the output register.
   ecei_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_bus.opcode),
      .req_easing_type   (req_bus.easing_type),
      .req_operand_value (req_bus.operand_value),
      .rsp_result_value  (rsp_bus.result_value)
   );

endmodule
